// ===== rtl/cec_pkg.sv =====
// ----------------------------------------------------------------------------
// cec_pkg
// Shared types and codes of the classification error counter.
// ----------------------------------------------------------------------------
package cec_pkg;

  // row tag codes, taken from the first element of a row
  localparam logic [1:0] KIND_LABELLED = 2'd0;
  localparam logic [1:0] KIND_MISSING  = 2'd1;
  localparam logic [1:0] KIND_SEQ_END  = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_ARGMAX = 1'b0;
  localparam logic CFG_IDX_SEQ    = 1'b1;

  // per-element control fields of one input beat
  typedef struct packed {
    logic [1:0] truth_kind;
    logic       row_last;
    logic       new_set;
  } ctrl_t;

endpackage

// ===== rtl/cec_if.sv =====
// ----------------------------------------------------------------------------
// cec_in_if / cec_out_if
// Valid/ready channels carrying score elements in and error counts out.
// ----------------------------------------------------------------------------
interface cec_in_if #(
  parameter int SCORE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] predicted_score;
  logic signed [SCORE_BITS-1:0] truth_score;
  logic [1:0]                   truth_kind;
  logic                         row_last;
  logic                         new_set;

  modport source (output valid, predicted_score, truth_score, truth_kind, row_last, new_set,
                  input ready);
  modport sink   (input valid, predicted_score, truth_score, truth_kind, row_last, new_set,
                  output ready);
endinterface

interface cec_out_if #(
  parameter int COUNT_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] wrong_count;
  logic [COUNT_BITS-1:0] valid_count;

  modport source (output valid, wrong_count, valid_count, input ready);
  modport sink   (input valid, wrong_count, valid_count, output ready);
endinterface

// ===== rtl/cec_in_reg.sv =====
// ----------------------------------------------------------------------------
// cec_in_reg
// Input register: captures one element beat and holds it for the core.
// ----------------------------------------------------------------------------
module cec_in_reg #(
  parameter int SCORE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cec_in_if.sink                       in_ch,
  input  logic                         adv,
  output logic                         s1_valid,
  output logic signed [SCORE_BITS-1:0] s1_pred,
  output logic signed [SCORE_BITS-1:0] s1_truth,
  output cec_pkg::ctrl_t               s1_ctrl
);
  import cec_pkg::*;

  logic                         s1_v_r, s1_v_nxt;
  logic signed [SCORE_BITS-1:0] pred_r, truth_r;
  ctrl_t                        ctrl_r;
  logic                         take;

  // register is free when empty or drained by the core this cycle
  assign in_ch.ready = adv || !s1_v_r;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_ch.ready) begin
      s1_v_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      pred_r              <= in_ch.predicted_score;
      truth_r             <= in_ch.truth_score;
      ctrl_r.truth_kind   <= in_ch.truth_kind;
      ctrl_r.row_last     <= in_ch.row_last;
      ctrl_r.new_set      <= in_ch.new_set;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_pred  = pred_r;
  assign s1_truth = truth_r;
  assign s1_ctrl  = ctrl_r;

endmodule

// ===== rtl/cec_core.sv =====
// ----------------------------------------------------------------------------
// cec_core
// Running argmax of both rows, error flags, saturating totals, result valid.
// ----------------------------------------------------------------------------
module cec_core #(
  parameter int MAX_CLASSES = 256,
  parameter int SCORE_BITS  = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  logic signed [SCORE_BITS-1:0] s1_pred,
  input  logic signed [SCORE_BITS-1:0] s1_truth,
  input  cec_pkg::ctrl_t               s1_ctrl,
  output logic                         adv,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COUNT_BITS-1:0]        wrong_count,
  output logic [COUNT_BITS-1:0]        valid_count,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic                         cfg_data
);
  import cec_pkg::*;

  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam logic [IDX_W-1:0] POS_MAX = IDX_W'(MAX_CLASSES - 1);

  logic signed [SCORE_BITS-1:0] pb_r, pb_nxt, tb_r, tb_nxt;
  logic [IDX_W-1:0]             pbi_r, pbi_nxt, tbi_r, tbi_nxt, pos_r, pos_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic                         fvd_r, fvd_nxt, err_r, err_nxt, start_r, start_nxt;
  logic [COUNT_BITS-1:0]        wrong_r, wrong_nxt, valid_r, valid_nxt;
  logic                         out_v_r, out_v_nxt;
  logic                         cfg_argmax_r, cfg_seq_r;

  logic                         fire, first, labelled, differ, err_row;
  logic [IDX_W-1:0]             pos_eff;
  logic [COUNT_BITS-1:0]        wrong_inc, valid_inc;

  // whole datapath moves when the result slot is free or being taken
  assign adv  = !out_v_r || out_ready;
  assign fire = s1_valid && adv;

  assign wrong_inc = (&wrong_r) ? wrong_r : wrong_r + COUNT_BITS'(1);
  assign valid_inc = (&valid_r) ? valid_r : valid_r + COUNT_BITS'(1);

  // per-element update
  always_comb begin
    pb_nxt    = pb_r;
    tb_nxt    = tb_r;
    pbi_nxt   = pbi_r;
    tbi_nxt   = tbi_r;
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    fvd_nxt   = fvd_r;
    err_nxt   = err_r;
    start_nxt = start_r;
    wrong_nxt = wrong_r;
    valid_nxt = valid_r;
    out_v_nxt = out_v_r && !out_ready;
    pos_eff   = s1_ctrl.new_set ? '0 : pos_r;
    first     = (pos_eff == '0);
    labelled  = 1'b0;
    differ    = 1'b0;
    err_row   = 1'b0;
    if (fire) begin
      // new data set clears totals and sequence tracking
      if (s1_ctrl.new_set) begin
        wrong_nxt = '0;
        valid_nxt = '0;
        err_nxt   = 1'b0;
        start_nxt = 1'b1;
      end
      // running maximum, first one wins on a tie
      if (first) begin
        kind_nxt = (s1_ctrl.truth_kind == KIND_LABELLED ||
                    s1_ctrl.truth_kind == KIND_SEQ_END) ? s1_ctrl.truth_kind : KIND_MISSING;
        pb_nxt   = s1_pred;
        pbi_nxt  = '0;
        tb_nxt   = s1_truth;
        tbi_nxt  = '0;
        fvd_nxt  = (s1_pred != s1_truth);
      end else begin
        if (s1_pred > pb_r) begin
          pb_nxt  = s1_pred;
          pbi_nxt = pos_eff;
        end
        if (s1_truth > tb_r) begin
          tb_nxt  = s1_truth;
          tbi_nxt = pos_eff;
        end
      end
      pos_nxt = (pos_eff < POS_MAX) ? pos_eff + IDX_W'(1) : pos_eff;
      // row end: score the row and emit a result
      if (s1_ctrl.row_last) begin
        pos_nxt   = '0;
        out_v_nxt = 1'b1;
        labelled  = (kind_nxt == KIND_LABELLED);
        differ    = cfg_argmax_r ? (pbi_nxt != tbi_nxt) : fvd_nxt;
        if (!cfg_seq_r) begin
          if (labelled) begin
            valid_nxt = s1_ctrl.new_set ? COUNT_BITS'(1) : valid_inc;
            if (differ) begin
              wrong_nxt = s1_ctrl.new_set ? COUNT_BITS'(1) : wrong_inc;
            end
          end
        end else begin
          err_row = err_nxt || (labelled && differ);
          if (start_nxt && labelled) begin
            valid_nxt = s1_ctrl.new_set ? COUNT_BITS'(1) : valid_inc;
          end
          if (kind_nxt == KIND_SEQ_END) begin
            if (err_row) begin
              wrong_nxt = s1_ctrl.new_set ? COUNT_BITS'(1) : wrong_inc;
            end
            err_nxt   = 1'b0;
            start_nxt = 1'b1;
          end else begin
            err_nxt   = err_row;
            start_nxt = 1'b0;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r    <= '0;
      tb_r    <= '0;
      pbi_r   <= '0;
      tbi_r   <= '0;
      pos_r   <= '0;
      kind_r  <= KIND_LABELLED;
      fvd_r   <= 1'b0;
      err_r   <= 1'b0;
      start_r <= 1'b1;
      wrong_r <= '0;
      valid_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      pb_r    <= pb_nxt;
      tb_r    <= tb_nxt;
      pbi_r   <= pbi_nxt;
      tbi_r   <= tbi_nxt;
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      fvd_r   <= fvd_nxt;
      err_r   <= err_nxt;
      start_r <= start_nxt;
      wrong_r <= wrong_nxt;
      valid_r <= valid_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_argmax_r <= 1'b1;
      cfg_seq_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_ARGMAX: cfg_argmax_r <= cfg_data;
        CFG_IDX_SEQ:    cfg_seq_r    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // totals only change when the core advances, so they double as result
  assign out_valid   = out_v_r;
  assign wrong_count = wrong_r;
  assign valid_count = valid_r;

  // row end always rewinds the position
  a_row_end_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_ctrl.row_last |=> pos_r == '0)
    else $error("position not cleared at row end");

  // mid-row element leaves a nonzero position
  a_mid_row_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1_ctrl.row_last |=> pos_r != '0)
    else $error("position cleared inside a row");

  // totals never fall except at a new data set
  a_wrong_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && s1_ctrl.new_set) |=> wrong_r >= $past(wrong_r))
    else $error("wrong total decreased");

  a_valid_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && s1_ctrl.new_set) |=> valid_r >= $past(valid_r))
    else $error("valid total decreased");

endmodule

// ===== rtl/classification_error_counter_top.sv =====
// ----------------------------------------------------------------------------
// classification_error_counter_top
// Counts misclassified and valid samples or sequences over streamed rows.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one element beat per cycle while in_ch.ready is high:
//   predicted and truth scores, the row tag (read on the first element of
//   a row), row_last and new_set. out_ch carries one result beat per row,
//   once the core has scored the last row element from the input register:
//   the saturating wrong and valid totals. cfg_wr_en/cfg_index/cfg_data
//   write compare_by_argmax (index 0) and count_sequences (index 1); write
//   only while no row result is pending.
// Path: input register, then the scoring logic into the totals registers.
// Throughput: one element per cycle while out_ch does not stall, bounded by
//   the running compare and total update in the core.
// Reset: totals, argmax state and flags clear, a sequence start is pending,
//   compare_by_argmax = 1 and count_sequences = 0.
// Stall: while a result beat waits on out_ch.ready the core holds; the input
//   register takes one more element only if empty, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module classification_error_counter_top #(
  parameter int MAX_CLASSES = 256,
  parameter int SCORE_BITS  = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cec_in_if.sink     in_ch,
  cec_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic       cfg_data
);
  import cec_pkg::*;

  logic                         adv;
  logic                         s1_valid;
  logic signed [SCORE_BITS-1:0] s1_pred, s1_truth;
  ctrl_t                        s1_ctrl;

  // element input register
  cec_in_reg #(
    .SCORE_BITS (SCORE_BITS)
  ) u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_pred  (s1_pred),
    .s1_truth (s1_truth),
    .s1_ctrl  (s1_ctrl)
  );

  // scoring and totals
  cec_core #(
    .MAX_CLASSES (MAX_CLASSES),
    .SCORE_BITS  (SCORE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_pred     (s1_pred),
    .s1_truth    (s1_truth),
    .s1_ctrl     (s1_ctrl),
    .adv         (adv),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .wrong_count (out_ch.wrong_count),
    .valid_count (out_ch.valid_count),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams rows of predicted and truth scores into the classification error
// counter under random sender gaps and receiver stalls, predicts the wrong
// and valid totals of every row end, and checks each result beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import cec_pkg::*;

  localparam int MAX_CLASSES   = 256;
  localparam int LAST_POSITION = MAX_CLASSES - 1;
  localparam int PHASE_ITEMS   = 170;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;

  // tag code that the package leaves unnamed, handled as a missing label
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] wrong;
    logic [31:0] valid;
  } counts_t;

  // running argmax and totals, one expected counts beat per row end
  class count_board;
    bit                 by_argmax;
    bit                 by_sequence;
    logic signed [15:0] pred_best;
    logic signed [15:0] truth_best;
    logic [7:0]         pred_idx;
    logic [7:0]         truth_idx;
    logic [7:0]         position;
    logic [1:0]         row_kind;
    bit                 first_differ;
    bit                 seq_err;
    bit                 seq_start;
    logic [31:0]        wrong_total;
    logic [31:0]        valid_total;
    counts_t            counts_q[$];
    int                 errors;

    function new();
      by_argmax    = 1'b1;
      by_sequence  = 1'b0;
      pred_best    = '0;
      truth_best   = '0;
      pred_idx     = '0;
      truth_idx    = '0;
      position     = '0;
      row_kind     = KIND_LABELLED;
      first_differ = 1'b0;
      seq_err      = 1'b0;
      seq_start    = 1'b1;
      wrong_total  = '0;
      valid_total  = '0;
      errors       = 0;
    endfunction

    function void set_config(bit argmax, bit sequences);
      by_argmax   = argmax;
      by_sequence = sequences;
    endfunction

    function int pending();
      return counts_q.size();
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // one accepted element beat
    function void note_element(logic signed [15:0] p, logic signed [15:0] t,
                               logic [1:0] kind, bit last, bit fresh);
      bit      labelled;
      bit      differ;
      counts_t c;
      if (fresh) begin
        wrong_total = '0;
        valid_total = '0;
        seq_err     = 1'b0;
        seq_start   = 1'b1;
        position    = '0;
      end
      // first element latches the tag and seeds both maxima
      if (position == 0) begin
        row_kind     = (kind == KIND_UNUSED) ? KIND_MISSING : kind;
        pred_best    = p;
        pred_idx     = '0;
        truth_best   = t;
        truth_idx    = '0;
        first_differ = (p != t);
      end else begin
        if (p > pred_best) begin
          pred_best = p;
          pred_idx  = position;
        end
        if (t > truth_best) begin
          truth_best = t;
          truth_idx  = position;
        end
      end
      if (position < LAST_POSITION) position++;
      if (!last) return;

      // row end: update totals
      position = '0;
      labelled = (row_kind == KIND_LABELLED);
      differ   = by_argmax ? (pred_idx != truth_idx) : first_differ;
      if (!by_sequence) begin
        if (labelled) begin
          valid_total = bump(valid_total);
          if (differ) wrong_total = bump(wrong_total);
        end
      end else begin
        if (labelled && differ) seq_err = 1'b1;
        if (seq_start) begin
          if (labelled) valid_total = bump(valid_total);
          seq_start = 1'b0;
        end
        if (row_kind == KIND_SEQ_END) begin
          if (seq_err) begin
            wrong_total = bump(wrong_total);
            seq_err     = 1'b0;
          end
          seq_start = 1'b1;
        end
      end
      c.wrong = wrong_total;
      c.valid = valid_total;
      counts_q = {counts_q, c};
    endfunction

    // one accepted result beat against the oldest expectation
    task check_counts(logic [31:0] wrong, logic [31:0] valid);
      counts_t c;
      if (counts_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result wrong=%0d valid=%0d", wrong, valid));
        return;
      end
      c = counts_q.pop_front();
      if (wrong !== c.wrong)
        report_mismatch($sformatf("wrong_count %0d, expected %0d", wrong, c.wrong));
      if (valid !== c.valid)
        report_mismatch($sformatf("valid_count %0d, expected %0d", valid, c.valid));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_index;
  logic cfg_data;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int quiet_cycles;
  int phase_items;

  count_board board = new();

  cec_in_if  #(.SCORE_BITS(16)) in_ch ();
  cec_out_if #(.COUNT_BITS(32)) out_ch ();

  classification_error_counter_top #(
    .MAX_CLASSES(MAX_CLASSES),
    .SCORE_BITS (16),
    .COUNT_BITS (32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // beat monitor and idle counter
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_element(in_ch.predicted_score, in_ch.truth_score, in_ch.truth_kind,
                         in_ch.row_last, in_ch.new_set);
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_counts(out_ch.wrong_count, out_ch.valid_count);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // mostly small values so maxima tie and match, plus extremes and full range
  function automatic logic signed [15:0] rand_score();
    logic signed [15:0] v;
    int unsigned        r;
    r = $urandom_range(99);
    if (r < 60) begin
      v = 16'($urandom_range(4));
      v = v - 16'sd2;
    end else if (r < 80) begin
      case ($urandom_range(3))
        0: v = 16'sh7fff;
        1: v = 16'sh8000;
        2: v = 16'sh0000;
        default: v = 16'shffff;
      endcase
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  // one element beat, with random gaps before it
  task automatic send_element(input logic signed [15:0] p, input logic signed [15:0] t,
                              input logic [1:0] kind, input bit last, input bit fresh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.predicted_score <= p;
    in_ch.truth_score     <= t;
    in_ch.truth_kind      <= kind;
    in_ch.row_last        <= last;
    in_ch.new_set         <= fresh;
    do @(posedge clk); while (!in_ch.ready);
    phase_items++;
  endtask

  // one row of random scores; a long row puts its maxima near or past the last index
  task automatic send_row(input int len, input logic [1:0] kind, input bit fresh,
                          input bit long_row);
    logic signed [15:0] p;
    logic signed [15:0] t;
    logic [1:0]         k;
    bit                 f;
    for (int i = 0; i < len; i++) begin
      if (long_row && i >= 250) begin
        p = 16'sd100 + 16'($urandom_range(50));
        t = ($urandom_range(99) < 30) ? p : 16'sd100 + 16'($urandom_range(50));
      end else if (long_row) begin
        p = 16'($urandom_range(4));
        t = 16'($urandom_range(4));
      end else begin
        p = rand_score();
        t = ($urandom_range(99) < 30) ? p : rand_score();
      end
      k = (i == 0) ? kind : 2'($urandom_range(3));
      f = (i == 0) ? fresh : ($urandom_range(99) == 0);
      send_element(p, t, k, i == len - 1, f);
    end
  endtask

  function automatic logic [1:0] rand_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return KIND_LABELLED;
    if (r < 75) return KIND_MISSING;
    if (r < 93) return KIND_SEQ_END;
    return KIND_UNUSED;
  endfunction

  // drop valid, drain every expected beat, then let the pipeline settle
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input bit argmax, input bit sequences);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_ARGMAX;
    cfg_data  <= argmax;
    @(posedge clk);
    cfg_index <= CFG_IDX_SEQ;
    cfg_data  <= sequences;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_config(argmax, sequences);
  endtask

  // stimulus
  initial begin
    bit argmax_set [4];
    bit seq_set    [4];
    argmax_set = '{1'b1, 1'b0, 1'b1, 1'b0};
    seq_set    = '{1'b0, 1'b1, 1'b1, 1'b0};

    rst_n                 <= 1'b0;
    cfg_wr_en             <= 1'b0;
    cfg_index             <= CFG_IDX_ARGMAX;
    cfg_data              <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.predicted_score <= '0;
    in_ch.truth_score     <= '0;
    in_ch.truth_kind      <= KIND_LABELLED;
    in_ch.row_last        <= 1'b0;
    in_ch.new_set         <= 1'b0;
    hold_req      = 1'b0;
    phase_items   = 0;
    send_idle_pct = 21;
    recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // per-sample argmax mode from reset
    // single-element row opening a set, extreme scores
    send_element(16'sh7fff, 16'sh8000, KIND_LABELLED, 1, 1);
    // argmax differs; tags after the first element are ignored
    send_element(16'sh8000, 16'sh0000, KIND_LABELLED, 0, 0);
    send_element(16'sh7fff, 16'sh0000, KIND_SEQ_END, 0, 0);
    send_element(16'sh0005, 16'sh7fff, KIND_UNUSED, 1, 0);
    // equal scores keep the first maximum
    send_element(16'sh0004, 16'sh0004, KIND_LABELLED, 0, 0);
    send_element(16'sh0004, 16'sh0004, KIND_LABELLED, 0, 0);
    send_element(16'sh0004, 16'sh0004, KIND_LABELLED, 1, 0);
    // missing label and unused tag are not counted
    send_element(16'sh0001, 16'shffff, KIND_MISSING, 0, 0);
    send_element(16'shffff, 16'sh0001, KIND_LABELLED, 1, 0);
    send_element(16'sh0001, 16'sh0000, KIND_UNUSED, 0, 0);
    send_element(16'sh0000, 16'sh0001, KIND_LABELLED, 1, 0);
    // sequence end row in sample mode
    send_element(16'sh0003, 16'sh0003, KIND_SEQ_END, 1, 0);
    // new set arriving inside a row restarts it
    send_element(16'sh0009, 16'sh0000, KIND_LABELLED, 0, 0);
    send_element(16'sh0000, 16'sh0009, KIND_LABELLED, 1, 1);
    finish_phase();

    // per-sequence mode comparing first values
    write_config(1'b0, 1'b1);
    send_element(16'sh0005, 16'sh0005, KIND_LABELLED, 1, 0);
    send_element(16'sh0005, 16'sh0006, KIND_LABELLED, 1, 0);
    send_element(16'sh0000, 16'sh0000, KIND_SEQ_END, 1, 0);
    // sequence opened by a missing label is not valid but still wrong
    send_element(16'sh0001, 16'sh0002, KIND_MISSING, 1, 0);
    send_element(16'sh0001, 16'sh0002, KIND_LABELLED, 1, 0);
    send_element(16'sh0000, 16'sh0000, KIND_SEQ_END, 1, 0);
    // open erroneous sequence dropped by a new set
    send_element(16'sh0001, 16'sh0002, KIND_LABELLED, 1, 0);
    send_element(16'sh0003, 16'sh0003, KIND_LABELLED, 1, 1);
    finish_phase();

    // random rows over every register setting and idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      write_config(argmax_set[ph], seq_set[ph]);
      case (ph % 3)
        0: begin send_idle_pct = 21; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 21; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      phase_items = 0;
      if (ph == 0) send_row($urandom_range(256, 300), KIND_LABELLED, 1'b0, 1'b1);
      while (phase_items < PHASE_ITEMS)
        send_row($urandom_range(1, 6), rand_kind(), $urandom_range(99) < 4, 1'b0);
      finish_phase();
    end

    if (board.errors == 0 && board.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
